[design/insertion_sorter_macros.svh]
// Assertion macros used by the checker file.
`ifndef INSERTION_SORTER_MACROS_SVH
`define INSERTION_SORTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ISORT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ISORT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/isort_pkg.sv]
`timescale 1ns / 1ps

package isort_pkg;

   localparam int VALUE_W = 32;

   typedef struct packed {
      logic insert;
      logic pop;
   } isort_cmd_type;

   typedef struct packed {
      logic last_entry;
   } isort_status_type;

endpackage

[design/isort_ctrl.sv]
`timescale 1ns / 1ps

module isort_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_last,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  isort_pkg::isort_status_type status,
   output isort_pkg::isort_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_COLLECT = 2'b01,
      ST_DRAIN   = 2'b10
   } isort_state_type;

   isort_state_type state_ff, state_in;

   assign req_ready  = (state_ff == ST_COLLECT);
   assign rsp_valid  = (state_ff == ST_DRAIN);
   assign cmd.insert = req_valid && req_ready;
   assign cmd.pop    = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            // a transaction marked last closes the set
            if (cmd.insert && req_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (cmd.pop && status.last_entry) state_in = ST_COLLECT;
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/isort_datapath.sv]
`timescale 1ns / 1ps

module isort_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  isort_pkg::isort_cmd_type             cmd,
   output isort_pkg::isort_status_type          status,
   input  logic signed [isort_pkg::VALUE_W-1:0] key,
   input  logic                                 cfg_write,
   input  logic                                 cfg_order_descending,
   output logic signed [isort_pkg::VALUE_W-1:0] head_value,
   output logic                                 overflow
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic signed [isort_pkg::VALUE_W-1:0] cell_ff [DEPTH];
   logic signed [isort_pkg::VALUE_W-1:0] cell_in [DEPTH];
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             dropped_ff, dropped_in;
   logic             order_ff, order_in;
   logic [DEPTH-1:0] moves;      // entry must sit behind the new key
   logic [DEPTH-1:0] shift_en;   // entry and all valid ones after it move up
   logic             room;

   assign room = (fill_ff != CNT_W'(DEPTH));

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         localparam logic [DEPTH-1:0] LowMask = (DEPTH'(1) << g) - DEPTH'(1);

         assign moves[g] = (CNT_W'(g) >= fill_ff) ||
                           (order_ff ? (cell_ff[g] < key) : (cell_ff[g] > key));
         assign shift_en[g] = &(moves | LowMask);

         always_comb begin
            cell_in[g] = cell_ff[g];
            if (cmd.insert && room && (CNT_W'(g) <= fill_ff) && shift_en[g]) begin
               if (g == 0) begin
                  cell_in[g] = key;
               end else begin
                  cell_in[g] = shift_en[(g == 0) ? 0 : g - 1] ?
                               cell_ff[(g == 0) ? 0 : g - 1] : key;
               end
            end else if (cmd.pop) begin
               // advance the list toward the head
               cell_in[g] = cell_ff[(g == DEPTH - 1) ? g : g + 1];
            end
         end

         always_ff @(posedge clock) begin
            cell_ff[g] <= cell_in[g];
         end
      end
   endgenerate

   always_comb begin
      fill_in    = fill_ff;
      dropped_in = dropped_ff;
      order_in   = cfg_write ? cfg_order_descending : order_ff;
      if (cmd.insert) begin
         if (room) fill_in = fill_ff + CNT_W'(1);
         else      dropped_in = 1'b1;
      end else if (cmd.pop) begin
         fill_in = fill_ff - CNT_W'(1);
         if (status.last_entry) dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         dropped_ff <= 1'b0;
         order_ff   <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         dropped_ff <= dropped_in;
         order_ff   <= order_in;
      end
   end

   assign status.last_entry = (fill_ff == CNT_W'(1));
   assign head_value        = cell_ff[0];
   assign overflow          = dropped_ff;

endmodule

[design/insertion_sorter.sv]
`timescale 1ns / 1ps
// Insertion sorter for signed 32-bit values.
// req_ channel: one value per transaction, req_last marks the end of a set.
// Values are taken one per cycle and placed into a row of DEPTH compare
// cells; all cells compare against the new value at once and shift on the
// edge that accepts it. A new value goes behind equal ones (stable).
// rsp_ channel: after the last value is accepted, the first result is valid
// on the next cycle and the set streams out one result per cycle from the
// head cell; rsp_final_res marks the final one. While a set drains req_ready
// stays low; a stalled receiver simply holds the head result in place.
// Values beyond DEPTH are dropped and rsp_overflow is high on every result
// of that set. csr_ channel sets the order (0 ascending, 1 descending); it
// is always ready and should be written while the block is idle.
// Reset empties the list, clears the overflow flag and selects ascending.
module insertion_sorter #(
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [isort_pkg::VALUE_W-1:0] req_value,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [isort_pkg::VALUE_W-1:0] rsp_sorted_value,
   output logic                                 rsp_final_res,
   output logic                                 rsp_overflow,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_order_descending
);

   isort_pkg::isort_cmd_type    cmd;
   isort_pkg::isort_status_type status;

   assign csr_ready     = 1'b1;
   assign rsp_final_res = status.last_entry;

   isort_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   isort_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .key                  (req_value),
      .cfg_write            (csr_valid && csr_ready),
      .cfg_order_descending (csr_order_descending),
      .head_value           (rsp_sorted_value),
      .overflow             (rsp_overflow)
   );

endmodule

[design/isort_checker.sv]
`timescale 1ns / 1ps
`include "insertion_sorter_macros.svh"

module isort_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 req_last,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [isort_pkg::VALUE_W-1:0] rsp_sorted_value,
   input logic                                 rsp_final_res,
   input logic                                 rsp_overflow
);

   // never take input while a set drains
   `ISORT_ASSERT_NOW(a_no_overlap, req_ready, !rsp_valid, "input taken during drain")

   `ISORT_ASSERT_NEXT(a_drain_starts, req_valid && req_ready && req_last, rsp_valid,
      "drain did not start after last transaction")

   `ISORT_ASSERT_NEXT(a_drain_continues, rsp_valid && rsp_ready && !rsp_final_res, rsp_valid,
      "drain stopped before final result")

   `ISORT_ASSERT_NEXT(a_back_to_collect, rsp_valid && rsp_ready && rsp_final_res,
      req_ready && !rsp_valid, "not ready after final result")

   `ISORT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_sorted_value) && $stable(rsp_final_res)
      && $stable(rsp_overflow), "stalled result changed")

endmodule

bind insertion_sorter isort_checker u_isort_checker (.*);

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int DEPTH = 64;
   localparam int VW    = isort_pkg::VALUE_W;
   localparam int TAIL  = 6;

   localparam logic ORDER_ASCENDING  = 1'b0;
   localparam logic ORDER_DESCENDING = 1'b1;

   localparam logic signed [VW-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VW-1:0] VALUE_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [VW-1:0] value;
      logic                 last;
   } sort_item_type;

   typedef struct packed {
      logic signed [VW-1:0] value;
      logic                 final_res;
      logic                 overflow;
   } sorted_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic signed [VW-1:0] req_value = '0;
   logic          req_last = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic signed [VW-1:0] rsp_sorted_value;
   logic          rsp_final_res;
   logic          rsp_overflow;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic          csr_order_descending = 1'b0;

   sort_item_type     pending_items[$];
   sorted_result_type expected_sorted[$];

   // shadow of the sorter's list and flags
   logic signed [VW-1:0] shadow_list[$];
   logic          shadow_dropped = 1'b0;
   logic          shadow_descending = ORDER_ASCENDING;

   int fail_count = 0;
   int req_gap = 0;
   int req_stretch = 0;
   int rsp_hold = 0;
   int rsp_stretch = 0;
   int rsp_pause;
   sort_item_type next_item;
   sorted_result_type got, want;

   insertion_sorter #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_value           (req_value),
      .req_last            (req_last),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sorted_value    (rsp_sorted_value),
      .rsp_final_res       (rsp_final_res),
      .rsp_overflow        (rsp_overflow),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_order_descending(csr_order_descending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly no idle or a short one, a few long ones, and now and then a long run with none.
   function automatic int idle_length(inout int stretch);
      int r;
      if (stretch > 0) begin
         stretch--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         stretch = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic must_follow(logic signed [VW-1:0] a, logic signed [VW-1:0] b);
      if (shadow_descending == ORDER_DESCENDING) return a < b;
      return a > b;
   endfunction

   // Insert behind equal entries; on a last mark, flush the list as expectations.
   task automatic place_value(input logic signed [VW-1:0] v, input logic last);
      int j;
      int n;
      if (shadow_list.size() < DEPTH) begin
         shadow_list.push_back(v);
         j = shadow_list.size() - 1;
         while (j > 0 && must_follow(shadow_list[j-1], v)) begin
            shadow_list[j] = shadow_list[j-1];
            j--;
         end
         shadow_list[j] = v;
      end else begin
         shadow_dropped = 1'b1;
      end
      if (last) begin
         n = shadow_list.size();
         for (int k = 0; k < n; k++)
            expected_sorted.push_back('{value: shadow_list[k], final_res: (k == n - 1),
                                        overflow: shadow_dropped});
         shadow_list.delete();
         shadow_dropped = 1'b0;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (pending_items.size() > 0) begin
            next_item = pending_items.pop_front();
            req_valid <= 1'b1;
            req_value <= next_item.value;
            req_last  <= next_item.last;
            req_gap   <= idle_length(req_stretch);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else if (rsp_valid && rsp_ready) begin
         rsp_pause = idle_length(rsp_stretch);
         rsp_ready <= (rsp_pause == 0);
         rsp_hold  <= (rsp_pause == 0) ? 0 : rsp_pause - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            shadow_descending = csr_order_descending;
         if (req_valid && req_ready)
            place_value(req_value, req_last);
         if (rsp_valid && rsp_ready) begin
            got = '{value: rsp_sorted_value, final_res: rsp_final_res,
                    overflow: rsp_overflow};
            if (expected_sorted.size() == 0) begin
               $error("unexpected transaction: sorted_value %0d", got.value);
               fail_count++;
            end else begin
               want = expected_sorted.pop_front();
               if (got.value !== want.value) begin
                  $error("sorted_value: expected %0d, got %0d", want.value, got.value);
                  fail_count++;
               end
               if (got.final_res !== want.final_res) begin
                  $error("final_res: expected %0b, got %0b", want.final_res, got.final_res);
                  fail_count++;
               end
               if (got.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                  fail_count++;
               end
            end
         end
      end
   end

   task automatic queue_value(input logic signed [VW-1:0] v, input logic last);
      pending_items.push_back('{value: v, last: last});
   endtask

   // Drain the input queue and all expected results, then let the block settle.
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_sorted.size() != 0);
      repeat (TAIL) @(posedge clock);
   endtask

   task automatic write_order(input logic descending);
      @(posedge clock);
      csr_valid            <= 1'b1;
      csr_order_descending <= descending;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [VW-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: begin
            case ($urandom_range(0, 3))
               0: return VALUE_MAX;
               1: return VALUE_MIN;
               2: return '0;
               default: return -1;
            endcase
         end
         1, 2, 3: return $signed($urandom_range(0, 16)) - 8;
         default: return $signed($urandom);
      endcase
   endfunction

   initial begin
      int sent;
      int size;
      int split;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ascending set with both extremes and duplicates
      write_order(ORDER_ASCENDING);
      queue_value(5, 1'b0);
      queue_value(-3, 1'b0);
      queue_value(VALUE_MAX, 1'b0);
      queue_value(VALUE_MIN, 1'b0);
      queue_value(0, 1'b0);
      queue_value(-1, 1'b0);
      queue_value(1, 1'b0);
      queue_value(5, 1'b0);
      queue_value(VALUE_MIN, 1'b0);
      queue_value(7, 1'b1);
      // a set of one
      queue_value(42, 1'b1);
      wait_quiet();

      write_order(ORDER_DESCENDING);
      queue_value(3, 1'b0);
      queue_value(-3, 1'b0);
      queue_value(VALUE_MAX, 1'b0);
      queue_value(VALUE_MIN, 1'b0);
      queue_value(3, 1'b0);
      queue_value(0, 1'b1);
      queue_value(10, 1'b0);
      queue_value(20, 1'b0);
      wait_quiet();

      // flip the order halfway through a set
      write_order(ORDER_ASCENDING);
      queue_value(15, 1'b0);
      queue_value(5, 1'b1);
      wait_quiet();

      sent = 0;
      while (sent < 310) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_quiet();
            write_order($urandom_range(0, 1));
         end
         // now and then fill close to capacity or past it
         if ($urandom_range(0, 15) == 0)
            size = $urandom_range(DEPTH - 1, DEPTH + 6);
         else
            size = $urandom_range(1, 12);
         split = (size > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, size - 1) : size;
         for (int i = 0; i < size; i++) begin
            if (i == split) begin
               wait_quiet();
               write_order($urandom_range(0, 1));
            end
            queue_value(pick_value(), i == size - 1);
         end
         sent += size;
      end
      wait_quiet();

      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
